// ----- rtl/wsd_pkg.sv -----
// Package for the websocket frame deframer: parse phases, event codes,
// opcodes, item and result types and the frame event function.
// No dependencies.
package wsd_pkg;

  localparam logic [2:0] PH_HDR1    = 3'd0;
  localparam logic [2:0] PH_HDR2    = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  localparam logic [2:0] EV_TEXT  = 3'd0;
  localparam logic [2:0] EV_PING  = 3'd1;
  localparam logic [2:0] EV_PONG  = 3'd2;
  localparam logic [2:0] EV_CLOSE = 3'd3;
  localparam logic [2:0] EV_SKIP  = 3'd4;

  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;
  localparam logic [3:0] OPC_PONG  = 4'hA;

  localparam logic       OP_DATA    = 1'b0;
  localparam logic       OP_RESTART = 1'b1;

  localparam logic [6:0]  LEN16_CODE     = 7'd126;
  localparam logic [6:0]  LEN64_CODE     = 7'd127;
  localparam logic [63:0] PING_ECHO_MAX  = 64'd122;
  localparam logic [15:0] TEXT_LIMIT_RST = 16'd1024;
  localparam logic        KIND_TEXT      = 1'b0;
  localparam logic        KIND_PING      = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        payload_kind;
    logic        frame_done;
    logic [2:0]  frame_event;
    logic [15:0] message_length;
  } res_t;

  function automatic logic [2:0] event_code(input logic [3:0] kind, input logic deliver);
    logic [2:0] ev;
    ev = EV_SKIP;
    if (kind == OPC_TEXT) begin
      ev = deliver ? EV_TEXT : EV_SKIP;
    end else if (kind == OPC_PING) begin
      ev = deliver ? EV_PING : EV_SKIP;
    end else if (kind == OPC_PONG) begin
      ev = EV_PONG;
    end else if (kind == OPC_CLOSE) begin
      ev = EV_CLOSE;
    end
    return ev;
  endfunction

endpackage

// ----- rtl/wsd_in_stage.sv -----
// Input register of the websocket frame deframer: holds one stream transaction
// until the parser takes it. Depends on wsd_pkg.
module wsd_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_op,
  input  logic [7:0]    in_byte,
  input  logic          take,
  output logic          item_valid,
  output wsd_pkg::item_t item
);
  import wsd_pkg::*;

  logic  v_r, v_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  assign in_stall   = v_r && !take;
  assign accept     = in_valid && !in_stall;
  assign item_valid = v_r;
  assign item       = item_r;

  always_comb begin
    v_nxt    = v_r;
    item_nxt = item_r;
    if (accept) begin
      v_nxt         = 1'b1;
      item_nxt.op   = in_op;
      item_nxt.data = in_byte;
    end else if (take) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

// ----- rtl/wsd_parser.sv -----
// Frame parser of the websocket frame deframer: header decode, unmasking,
// frame events, text limit register and result register. Depends on wsd_pkg.
module wsd_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data,
  input  logic           item_valid,
  input  wsd_pkg::item_t item,
  output logic           take,
  output logic           out_valid,
  input  logic           out_stall,
  output wsd_pkg::res_t  res
);
  import wsd_pkg::*;

  logic [15:0] text_limit_r;
  logic [2:0]  phase_r, phase_nxt;
  logic        closed_r, closed_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic        masked_r, masked_nxt;
  logic [3:0]  left_r, left_nxt;
  logic [63:0] total_r, total_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic        deliver_r, deliver_nxt;
  logic        out_v_r, out_v_nxt;
  res_t        res_r, res_c;
  logic        res_valid;
  logic        end_len, begin_pl, finish;
  logic [7:0]  fin_byte;
  logic        fin_bvalid, fin_kind;
  logic [7:0]  key_sel, plain;
  logic [2:0]  ev;

  assign take      = item_valid && (!out_v_r || !out_stall);
  assign out_valid = out_v_r;
  assign res       = res_r;

  always_comb begin
    unique case (seen_r)
      2'd0:    key_sel = key_r[31:24];
      2'd1:    key_sel = key_r[23:16];
      2'd2:    key_sel = key_r[15:8];
      default: key_sel = key_r[7:0];
    endcase
  end

  assign plain = item.data ^ key_sel;

  always_comb begin
    phase_nxt   = phase_r;
    closed_nxt  = closed_r;
    fin_nxt     = fin_r;
    kind_nxt    = kind_r;
    masked_nxt  = masked_r;
    left_nxt    = left_r;
    total_nxt   = total_r;
    remain_nxt  = remain_r;
    key_nxt     = key_r;
    seen_nxt    = seen_r;
    deliver_nxt = deliver_r;
    res_c       = '0;
    res_valid   = 1'b0;
    end_len     = 1'b0;
    begin_pl    = 1'b0;
    finish      = 1'b0;
    fin_byte    = 8'd0;
    fin_bvalid  = 1'b0;
    fin_kind    = KIND_TEXT;
    ev          = EV_SKIP;
    if (item.op == OP_RESTART) begin
      closed_nxt  = 1'b0;
      phase_nxt   = PH_HDR1;
      fin_nxt     = 1'b0;
      kind_nxt    = 4'd0;
      masked_nxt  = 1'b0;
      left_nxt    = 4'd0;
      total_nxt   = 64'd0;
      remain_nxt  = 64'd0;
      key_nxt     = 32'd0;
      seen_nxt    = 2'd0;
      deliver_nxt = 1'b0;
    end else if (!closed_r) begin
      unique case (phase_r)
        PH_HDR2: begin
          masked_nxt = item.data[7];
          key_nxt    = 32'd0;
          total_nxt  = 64'd0;
          if (item.data[6:0] == LEN16_CODE) begin
            left_nxt  = 4'd2;
            phase_nxt = PH_EXT;
          end else if (item.data[6:0] == LEN64_CODE) begin
            left_nxt  = 4'd8;
            phase_nxt = PH_EXT;
          end else begin
            total_nxt = {57'd0, item.data[6:0]};
            end_len   = 1'b1;
          end
        end
        PH_EXT: begin
          total_nxt = {total_r[55:0], item.data};
          left_nxt  = left_r - 4'd1;
          end_len   = (left_r == 4'd1);
        end
        PH_MASK: begin
          key_nxt  = {key_r[23:0], item.data};
          left_nxt = left_r - 4'd1;
          begin_pl = (left_r == 4'd1);
        end
        PH_PAYLOAD: begin
          remain_nxt = remain_r - 64'd1;
          seen_nxt   = seen_r + 2'd1;
          if (remain_r == 64'd1) begin
            finish     = 1'b1;
            fin_byte   = deliver_r ? plain : 8'd0;
            fin_bvalid = deliver_r;
            fin_kind   = deliver_r && (kind_r == OPC_PING);
          end else if (deliver_r) begin
            res_valid          = 1'b1;
            res_c.payload_byte = plain;
            res_c.byte_valid   = 1'b1;
            res_c.payload_kind = (kind_r == OPC_PING);
          end
        end
        default: begin
          fin_nxt   = item.data[7];
          kind_nxt  = item.data[3:0];
          phase_nxt = PH_HDR2;
        end
      endcase
      if (end_len) begin
        if (masked_nxt) begin
          phase_nxt = PH_MASK;
          left_nxt  = 4'd4;
        end else begin
          begin_pl = 1'b1;
        end
      end
      if (begin_pl) begin
        seen_nxt    = 2'd0;
        deliver_nxt = ((kind_r == OPC_TEXT) && fin_r && (total_nxt < {48'd0, text_limit_r}))
                   || ((kind_r == OPC_PING) && (total_nxt <= PING_ECHO_MAX));
        if (total_nxt == 64'd0) begin
          finish = 1'b1;
        end else begin
          phase_nxt  = PH_PAYLOAD;
          remain_nxt = total_nxt;
        end
      end
      if (finish) begin
        ev                   = event_code(kind_r, deliver_nxt);
        res_valid            = 1'b1;
        res_c.payload_byte   = fin_byte;
        res_c.byte_valid     = fin_bvalid;
        res_c.payload_kind   = fin_kind;
        res_c.frame_done     = 1'b1;
        res_c.frame_event    = ev;
        res_c.message_length = (total_nxt[63:16] != 48'd0) ? 16'hFFFF : total_nxt[15:0];
        phase_nxt            = PH_HDR1;
        if (ev == EV_CLOSE) begin
          closed_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (take) begin
      out_v_nxt = res_valid;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_limit_r <= TEXT_LIMIT_RST;
      phase_r      <= PH_HDR1;
      closed_r     <= 1'b0;
      fin_r        <= 1'b0;
      kind_r       <= 4'd0;
      masked_r     <= 1'b0;
      left_r       <= 4'd0;
      total_r      <= 64'd0;
      remain_r     <= 64'd0;
      key_r        <= 32'd0;
      seen_r       <= 2'd0;
      deliver_r    <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        text_limit_r <= cfg_data;
      end
      if (take) begin
        phase_r   <= phase_nxt;
        closed_r  <= closed_nxt;
        fin_r     <= fin_nxt;
        kind_r    <= kind_nxt;
        masked_r  <= masked_nxt;
        left_r    <= left_nxt;
        total_r   <= total_nxt;
        remain_r  <= remain_nxt;
        key_r     <= key_nxt;
        seen_r    <= seen_nxt;
        deliver_r <= deliver_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_r <= res_c;
    end
  end

`ifndef SYNTHESIS
  a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    take && closed_r && (item.op == OP_DATA) |=> !out_v_r)
    else $error("result produced while closed");
  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    take && (item.op == OP_RESTART) |=> !out_v_r && !closed_r && (phase_r == PH_HDR1))
    else $error("restart did not clear parser");
  a_mid_frame_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !res_r.frame_done |-> res_r.byte_valid && (res_r.frame_event == EV_TEXT)
    && (res_r.message_length == 16'd0))
    else $error("mid-frame result without payload byte");
  a_payload_remain: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (remain_r != 64'd0))
    else $error("payload phase with nothing left");
`endif

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// Websocket frame deframer, receive side.
// Input channel: in_valid / in_stall with in_op (data byte or restart) and
// in_byte. A transaction is taken when in_valid is high and in_stall is low.
// Result channel: out_valid / out_stall with the unmasked payload byte, its
// kind, and on the last result of a frame frame_done with the event code and
// the saturated payload length. Frames that are not delivered give one result
// only, on their last byte; header bytes give none unless the frame is empty.
// Configuration: cfg_we writes cfg_data into the text limit (reset 1024).
// Throughput is one byte per cycle while the receiver does not stall; each
// result passes the input register and the result register around the
// single-pass parser. When the receiver stalls a valid result, the result
// register holds and the parser takes nothing; in_stall rises once the
// input register is full. Synchronous reset clears the parser to the first
// header byte, clears the closed flag and empties both registers.
// Depends on wsd_pkg, wsd_in_stage and wsd_parser.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_byte_valid,
  output logic        out_payload_kind,
  output logic        out_frame_done,
  output logic [2:0]  out_frame_event,
  output logic [15:0] out_message_length
);
  import wsd_pkg::*;

  logic  item_valid;
  item_t item;
  logic  take;
  res_t  res;

  wsd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_byte    (in_byte),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  wsd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign out_payload_byte   = res.payload_byte;
  assign out_byte_valid     = res.byte_valid;
  assign out_payload_kind   = res.payload_kind;
  assign out_frame_done     = res.frame_done;
  assign out_frame_event    = res.frame_event;
  assign out_message_length = res.message_length;

endmodule

// ----- tb/tb_websocket_frame_deframer.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for websocket_frame_deframer: drives stream bytes and restarts,
// predicts every result with an in-bench frame parser and checks the result channel.
// Depends on wsd_pkg and the websocket_frame_deframer RTL.
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RUN_LIMIT   = CLK_PERIOD * 1_000_000;
  localparam int DRAIN_LIMIT = 200_000;
  localparam int IDLE_TAIL   = 8;
  localparam int LONG_HOLD   = 200;

  localparam logic [3:0] OPC_CONT   = 4'h0;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_RSVD   = 4'hF;

  typedef enum int {LEN7, LEN16, LEN64} len_form_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        in_op     = OP_DATA;
  logic [7:0]  in_byte   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_byte_valid;
  logic        out_payload_kind;
  logic        out_frame_done;
  logic [2:0]  out_frame_event;
  logic [15:0] out_message_length;

  item_t rx_byte_q[$];
  res_t  payload_event_q[$];
  item_t cur_item;

  int n_errors    = 0;
  int n_results   = 0;
  int n_live      = 0;
  int n_holds     = 0;
  int in_gap_max  = 0;
  int out_gap_max = 0;
  int gap_left    = 0;
  int stall_left  = 0;

  // Parser state of the predictor
  logic [2:0]  st_phase;
  logic        st_closed;
  logic        st_fin;
  logic [3:0]  st_kind;
  logic        st_masked;
  logic [3:0]  st_left;
  logic [63:0] st_total;
  logic [31:0] st_key;
  logic [63:0] st_seen;
  logic        st_deliver;
  logic [15:0] st_limit;

  websocket_frame_deframer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_byte_valid    (out_byte_valid),
    .out_payload_kind  (out_payload_kind),
    .out_frame_done    (out_frame_done),
    .out_frame_event   (out_frame_event),
    .out_message_length(out_message_length)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb_websocket_frame_deframer: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    $display("%0t: mismatch on %s: got %0d, want %0d (result %0d)", $time, what, got, want,
             n_results);
  endtask

  // ---------------- frame parser predictor ----------------

  task automatic clear_frame_state();
    st_phase   = PH_HDR1;
    st_fin     = 1'b0;
    st_kind    = '0;
    st_masked  = 1'b0;
    st_left    = '0;
    st_total   = '0;
    st_key     = '0;
    st_seen    = '0;
    st_deliver = 1'b0;
  endtask

  function automatic logic [2:0] frame_outcome();
    case (st_kind)
      OPC_TEXT:  return st_deliver ? EV_TEXT : EV_SKIP;
      OPC_PING:  return st_deliver ? EV_PING : EV_SKIP;
      OPC_PONG:  return EV_PONG;
      OPC_CLOSE: return EV_CLOSE;
      default:   return EV_SKIP;
    endcase
  endfunction

  task automatic emit_result(input logic [7:0] b, input logic valid, input logic knd,
                             input logic done);
    res_t r;
    r.payload_byte   = b;
    r.byte_valid     = valid;
    r.payload_kind   = knd;
    r.frame_done     = done;
    r.frame_event    = done ? frame_outcome() : 3'd0;
    r.message_length = !done ? 16'd0 : (st_total > 64'hFFFF) ? 16'hFFFF : st_total[15:0];
    payload_event_q.push_back(r);
    if (done) begin
      if (r.frame_event == EV_CLOSE) st_closed = 1'b1;
      st_phase = PH_HDR1;
    end
  endtask

  task automatic open_payload();
    st_seen    = '0;
    st_deliver = (st_kind == OPC_TEXT && st_fin && st_total < {48'd0, st_limit}) ||
                 (st_kind == OPC_PING && st_total <= PING_ECHO_MAX);
    if (st_total == 0) emit_result(8'd0, 1'b0, KIND_TEXT, 1'b1);
    else st_phase = PH_PAYLOAD;
  endtask

  task automatic length_known();
    if (st_masked) begin
      st_phase = PH_MASK;
      st_left  = 4'd4;
    end else begin
      open_payload();
    end
  endtask

  task automatic deframe_item(input item_t it);
    logic [7:0] b;
    logic [7:0] kb;
    logic [7:0] plain;
    logic       ping;
    b = it.data;
    if (it.op == OP_RESTART) begin
      st_closed = 1'b0;
      clear_frame_state();
      return;
    end
    if (st_closed) return;
    case (st_phase)
      PH_HDR2: begin
        st_masked = b[7];
        st_key    = '0;
        st_total  = '0;
        if (b[6:0] == LEN16_CODE) begin
          st_left  = 4'd2;
          st_phase = PH_EXT;
        end else if (b[6:0] == LEN64_CODE) begin
          st_left  = 4'd8;
          st_phase = PH_EXT;
        end else begin
          st_total = {57'd0, b[6:0]};
          length_known();
        end
      end
      PH_EXT: begin
        st_total = {st_total[55:0], b};
        st_left  = st_left - 4'd1;
        if (st_left == 0) length_known();
      end
      PH_MASK: begin
        st_key  = {st_key[23:0], b};
        st_left = st_left - 4'd1;
        if (st_left == 0) open_payload();
      end
      PH_PAYLOAD: begin
        case (st_seen[1:0])
          2'd0:    kb = st_key[31:24];
          2'd1:    kb = st_key[23:16];
          2'd2:    kb = st_key[15:8];
          default: kb = st_key[7:0];
        endcase
        plain   = b ^ kb;
        ping    = (st_kind == OPC_PING) ? KIND_PING : KIND_TEXT;
        st_seen = st_seen + 64'd1;
        if (st_seen == st_total) begin
          if (st_deliver) emit_result(plain, 1'b1, ping, 1'b1);
          else emit_result(8'd0, 1'b0, KIND_TEXT, 1'b1);
        end else if (st_deliver) begin
          emit_result(plain, 1'b1, ping, 1'b0);
        end
      end
      default: begin
        st_fin   = b[7];
        st_kind  = b[3:0];
        st_phase = PH_HDR2;
      end
    endcase
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_item(cur_item);
        gap_left = (in_gap_max > 0) ? $urandom_range(in_gap_max) : 0;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rx_byte_q.size() != 0) begin
          cur_item = rx_byte_q.pop_front();
          in_valid <= 1'b1;
          in_op    <= cur_item.op;
          in_byte  <= cur_item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  task automatic check_result();
    res_t want;
    if (payload_event_q.size() == 0) begin
      report_mismatch("result with nothing pending", out_frame_done, 0);
      return;
    end
    want = payload_event_q.pop_front();
    if (out_payload_byte !== want.payload_byte)
      report_mismatch("payload_byte", out_payload_byte, want.payload_byte);
    if (out_byte_valid !== want.byte_valid)
      report_mismatch("byte_valid", out_byte_valid, want.byte_valid);
    if (out_payload_kind !== want.payload_kind)
      report_mismatch("payload_kind", out_payload_kind, want.payload_kind);
    if (out_frame_done !== want.frame_done)
      report_mismatch("frame_done", out_frame_done, want.frame_done);
    if (out_frame_event !== want.frame_event)
      report_mismatch("frame_event", out_frame_event, want.frame_event);
    if (out_message_length !== want.message_length)
      report_mismatch("message_length", out_message_length, want.message_length);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
        n_results++;
        stall_left = (out_gap_max > 0) ? $urandom_range(out_gap_max) : 0;
        // hold off long enough to back the block up into its input
        if (rx_byte_q.size() > 40 &&
            ((n_holds == 0 && n_results >= 150) || (n_holds == 1 && n_results >= 700))) begin
          stall_left = LONG_HOLD;
          n_holds++;
        end
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // ---------------- stimulus ----------------

  task automatic push_item(input logic op, input logic [7:0] b, input bit live);
    item_t it;
    it.op   = op;
    it.data = b;
    rx_byte_q.push_back(it);
    if (live) n_live++;
  endtask

  function automatic logic [7:0] hdr1(input bit fin, input logic [3:0] opc);
    logic [2:0] rsv;
    rsv = 3'($urandom_range(7));
    return {fin, rsv, opc};
  endfunction

  task automatic send_frame(input logic [7:0] b1, input len_form_t form, input logic [63:0] len,
                            input bit masked, input int sent);
    logic [6:0] code;
    case (form)
      LEN16:   code = LEN16_CODE;
      LEN64:   code = LEN64_CODE;
      default: code = len[6:0];
    endcase
    push_item(OP_DATA, b1, 1'b1);
    push_item(OP_DATA, {masked, code}, 1'b1);
    if (form == LEN16) begin
      push_item(OP_DATA, len[15:8], 1'b1);
      push_item(OP_DATA, len[7:0], 1'b1);
    end
    if (form == LEN64) begin
      for (int i = 7; i >= 0; i--) push_item(OP_DATA, len[8*i +: 8], 1'b1);
    end
    if (masked) repeat (4) push_item(OP_DATA, 8'($urandom_range(255)), 1'b1);
    for (int i = 0; i < sent; i++) push_item(OP_DATA, 8'($urandom_range(255)), 1'b1);
  endtask

  task automatic rand_frame();
    int          r;
    int          s;
    bit          fin;
    bit          masked;
    logic [3:0]  opc;
    logic [63:0] len;
    len_form_t   form;
    r      = $urandom_range(99);
    s      = $urandom_range(99);
    fin    = 1'b1;
    masked = 1'($urandom_range(1));
    form   = LEN7;
    if (r < 40) opc = OPC_TEXT;
    else if (r < 47) begin
      opc = OPC_TEXT;
      fin = 1'b0;
    end else if (r < 65) opc = OPC_PING;
    else if (r < 73) opc = OPC_PONG;
    else if (r < 77) opc = OPC_CLOSE;
    else begin
      opc = 4'($urandom_range(15));
      fin = 1'($urandom_range(1));
    end
    if (s < 58) begin
      len = 64'($urandom_range(12));
    end else if (s < 70) begin
      len = 64'(118 + $urandom_range(7));
    end else if (s < 80) begin
      form = LEN16;
      len  = 64'($urandom_range(300));
    end else if (s < 86) begin
      form = LEN64;
      len  = 64'($urandom_range(40));
    end else if (s < 95) begin
      // land on either side of the text limit
      if (st_limit == 0) len = 64'($urandom_range(1));
      else if (st_limit <= 300) len = 64'(st_limit) - 64'd1 + 64'($urandom_range(2));
      else len = 64'($urandom_range(12));
      if (len > 125) form = LEN16;
    end else begin
      // broken sequences, each cut off by a restart
      s = $urandom_range(2);
      if (s == 0) send_frame(hdr1(fin, opc), LEN7, 64'd20, masked, $urandom_range(19));
      else if (s == 1) repeat ($urandom_range(1, 3)) push_item(OP_DATA, 8'($urandom_range(255)), 1'b1);
      else send_frame(hdr1(fin, opc), LEN64, {$urandom, $urandom}, masked, $urandom_range(4));
      push_item(OP_RESTART, 8'($urandom_range(255)), 1'b1);
      return;
    end
    send_frame(hdr1(fin, opc), form, len, masked, int'(len));
    if (opc == OPC_CLOSE) begin
      repeat ($urandom_range(3)) push_item(OP_DATA, 8'($urandom_range(255)), 1'b0);
      push_item(OP_RESTART, 8'($urandom_range(255)), 1'b1);
    end else if ($urandom_range(99) < 3) begin
      push_item(OP_RESTART, 8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic rand_stream(input int n_bytes);
    int target;
    target = n_live + n_bytes;
    while (n_live < target) rand_frame();
  endtask

  task automatic drain_stream();
    int spin;
    spin = 0;
    do begin
      @(negedge clk);
      spin++;
    end while ((rx_byte_q.size() != 0 || in_valid || payload_event_q.size() != 0) &&
               spin < DRAIN_LIMIT);
    repeat (IDLE_TAIL) @(negedge clk);
  endtask

  task automatic set_text_limit(input logic [15:0] v);
    drain_stream();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    st_limit = v;
  endtask

  initial begin
    st_closed = 1'b0;
    st_limit  = TEXT_LIMIT_RST;
    clear_frame_state();
    in_gap_max  = 14;
    out_gap_max = 14;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset text limit
    send_frame(hdr1(1'b1, OPC_TEXT), LEN7, 64'd0, 1'b0, 0);
    send_frame(hdr1(1'b1, OPC_TEXT), LEN7, 64'd5, 1'b1, 5);
    send_frame(hdr1(1'b0, OPC_TEXT), LEN7, 64'd3, 1'b1, 3);
    send_frame(hdr1(1'b1, OPC_PING), LEN7, 64'd3, 1'b1, 3);
    send_frame(hdr1(1'b1, OPC_PING), LEN7, 64'd122, 1'b0, 122);
    send_frame(hdr1(1'b1, OPC_PING), LEN7, 64'd123, 1'b1, 123);
    send_frame(hdr1(1'b1, OPC_PONG), LEN7, 64'd2, 1'b1, 2);
    send_frame(hdr1(1'b1, OPC_BINARY), LEN7, 64'd2, 1'b0, 2);
    send_frame(hdr1(1'b1, OPC_CONT), LEN7, 64'd0, 1'b0, 0);
    send_frame(hdr1(1'b1, OPC_RSVD), LEN7, 64'd1, 1'b1, 1);
    send_frame(hdr1(1'b1, OPC_TEXT), LEN16, 64'd130, 1'b1, 130);
    send_frame(hdr1(1'b1, OPC_TEXT), LEN64, 64'd5, 1'b0, 5);
    send_frame(hdr1(1'b1, OPC_BINARY), LEN64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6);
    push_item(OP_RESTART, 8'hFF, 1'b1);
    push_item(OP_DATA, 8'hFF, 1'b1);
    push_item(OP_RESTART, 8'h00, 1'b1);
    send_frame(hdr1(1'b1, OPC_CLOSE), LEN7, 64'd2, 1'b1, 2);
    push_item(OP_DATA, 8'h81, 1'b0);
    push_item(OP_DATA, 8'h00, 1'b0);
    push_item(OP_RESTART, 8'h00, 1'b1);
    send_frame(hdr1(1'b1, OPC_PING), LEN7, 64'd0, 1'b0, 0);

    set_text_limit(16'd4);
    send_frame(hdr1(1'b1, OPC_TEXT), LEN7, 64'd3, 1'b1, 3);
    send_frame(hdr1(1'b1, OPC_TEXT), LEN7, 64'd4, 1'b1, 4);
    set_text_limit(16'd0);
    send_frame(hdr1(1'b1, OPC_TEXT), LEN7, 64'd0, 1'b0, 0);
    send_frame(hdr1(1'b1, OPC_TEXT), LEN7, 64'd2, 1'b1, 2);
    set_text_limit(16'd1);
    send_frame(hdr1(1'b1, OPC_TEXT), LEN7, 64'd0, 1'b1, 0);
    send_frame(hdr1(1'b1, OPC_TEXT), LEN7, 64'd1, 1'b1, 1);

    // a frame past the 16-bit length range cut short by a restart, then one back to back
    set_text_limit(16'hFFFF);
    in_gap_max  = 0;
    out_gap_max = 0;
    send_frame(hdr1(1'b1, OPC_TEXT), LEN64, 64'd65536, 1'b1, 20);
    push_item(OP_RESTART, 8'h00, 1'b1);
    send_frame(hdr1(1'b1, OPC_TEXT), LEN16, 64'd300, 1'b1, 300);

    set_text_limit(16'($urandom_range(1, 40)));
    in_gap_max  = 14;
    out_gap_max = 14;
    rand_stream(200);

    set_text_limit(16'($urandom_range(100, 2000)));
    in_gap_max  = 0;
    out_gap_max = 0;
    rand_stream(150);

    set_text_limit(16'($urandom_range(1, 200)));
    in_gap_max  = 0;
    out_gap_max = 14;
    rand_stream(150);

    set_text_limit(16'hFFFF);
    in_gap_max  = 14;
    out_gap_max = 0;
    rand_stream(120);

    drain_stream();
    if (rx_byte_q.size() != 0 || payload_event_q.size() != 0)
      report_mismatch("results never delivered", payload_event_q.size(), 0);
    if (n_errors == 0) begin
      $display("tb_websocket_frame_deframer: done, clean");
    end else begin
      $display("tb_websocket_frame_deframer: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/wsd_pkg.sv
rtl/wsd_in_stage.sv
rtl/wsd_parser.sv
rtl/websocket_frame_deframer.sv
tb/tb_websocket_frame_deframer.sv
